[design/frsa_pkg.sv]
// Shared types, codes and defaults for the fenced ring suballocator.
package frsa_pkg;

  localparam int unsigned FRAME_SLOTS_DEF = 8;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned FENCE_W    = 64;
  localparam int unsigned FREED_W    = 4;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [SIZE_W-1:0] BUF_SIZE_RST = 32'd65536;

  // APB register map: one 32-bit register, word addressed
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_QUEUE_FULL = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_APPLY,
    S_FINISH,
    S_REL_FETCH,
    S_REL_TEST,
    S_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic alloc_chk;
    logic alloc_apply;
    logic finish;
    logic rel_pop;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic front_hit;
    logic out_free;
  } stat_t;

endpackage

[design/frsa_ctrl.sv]
// Controller state machine: sequences allocate, finish and release items.
module frsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [1:0]      s_axis_tuser,   // operation[1:0]
  input  frsa_pkg::stat_t stat_i,
  output frsa_pkg::cmd_t  cmd_o
);

  frsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      frsa_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          // the item lands in the datapath at this edge, so dispatch on the raw kind
          case (frsa_pkg::op_e'(s_axis_tuser))
            frsa_pkg::OP_ALLOC:   state_d = frsa_pkg::S_ALLOC_CHK;
            frsa_pkg::OP_FINISH:  state_d = frsa_pkg::S_FINISH;
            frsa_pkg::OP_RELEASE: state_d = frsa_pkg::S_REL_FETCH;
            default:              state_d = frsa_pkg::S_RESP;
          endcase
        end
      end
      frsa_pkg::S_ALLOC_CHK:   state_d = frsa_pkg::S_ALLOC_APPLY;
      frsa_pkg::S_ALLOC_APPLY: state_d = frsa_pkg::S_RESP;
      frsa_pkg::S_FINISH:      state_d = frsa_pkg::S_RESP;
      frsa_pkg::S_REL_FETCH: begin
        state_d = stat_i.q_empty ? frsa_pkg::S_RESP : frsa_pkg::S_REL_TEST;
      end
      frsa_pkg::S_REL_TEST: begin
        state_d = stat_i.front_hit ? frsa_pkg::S_REL_FETCH : frsa_pkg::S_RESP;
      end
      frsa_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          state_d = frsa_pkg::S_IDLE;
        end
      end
      default: state_d = frsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      frsa_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      frsa_pkg::S_ALLOC_CHK:   cmd_o.alloc_chk = 1'b1;
      frsa_pkg::S_ALLOC_APPLY: cmd_o.alloc_apply = 1'b1;
      frsa_pkg::S_FINISH:      cmd_o.finish = 1'b1;
      frsa_pkg::S_REL_TEST:    cmd_o.rel_pop = stat_i.front_hit;
      frsa_pkg::S_RESP:        cmd_o.load_out = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/frsa_dp.sv]
// Datapath: ring pointers, usage counters, frame queue memory, APB register, result stage.
module frsa_dp #(
  parameter int unsigned FRAME_SLOTS = frsa_pkg::FRAME_SLOTS_DEF,
  parameter int unsigned OFFSET_BITS = frsa_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [frsa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [frsa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frsa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [frsa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [frsa_pkg::APB_DATA_W-1:0]     prdata,
  input  frsa_pkg::cmd_t                      cmd_i,
  output frsa_pkg::stat_t                     stat_o
);

  localparam int unsigned PTR_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(FRAME_SLOTS + 1);
  localparam int unsigned CW    = ((OFFSET_BITS > frsa_pkg::SIZE_W) ?
                                   OFFSET_BITS : frsa_pkg::SIZE_W) + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FRAME_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FRAME_SLOTS);
  localparam logic [frsa_pkg::FREED_W-1:0] FREED_MAX = '1;

  function automatic logic [frsa_pkg::SIZE_W-1:0] sat_add32(
    input logic [frsa_pkg::SIZE_W-1:0] a,
    input logic [frsa_pkg::SIZE_W-1:0] b
  );
    logic [frsa_pkg::SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add32 = s[frsa_pkg::SIZE_W] ? '1 : s[frsa_pkg::SIZE_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // configuration
  logic [frsa_pkg::SIZE_W-1:0]  buf_size_q;
  logic [frsa_pkg::REG_IDX_W-1:0] cfg_idx;
  assign cfg_idx = paddr[frsa_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= frsa_pkg::BUF_SIZE_RST;
    end else if (psel && penable && pwrite && cfg_idx == frsa_pkg::REG_BUFFER_SIZE) begin
      buf_size_q <= pwdata;
    end
  end

  assign prdata = (cfg_idx == frsa_pkg::REG_BUFFER_SIZE) ? buf_size_q : '0;

  // captured item
  logic [frsa_pkg::SIZE_W-1:0]   size_q;
  logic [frsa_pkg::FENCE_W-1:0]  fence_q;

  // ring state
  logic [OFFSET_BITS-1:0]        head_q, tail_q;
  logic [frsa_pkg::SIZE_W-1:0]   used_q, frame_q;
  logic [PTR_W-1:0]              rd_ptr_q, wr_ptr_q;
  logic [CNT_W-1:0]              cnt_q;

  // allocate decision
  logic                          alloc_ok_q;
  logic                          wrap_q;
  logic [frsa_pkg::SIZE_W-1:0]   charge_q;
  logic [OFFSET_BITS-1:0]        new_tail_q;

  // result of the item in flight
  frsa_pkg::stat_e               res_stat_q;
  logic [frsa_pkg::SIZE_W-1:0]   res_ofs_q;
  logic [frsa_pkg::FREED_W-1:0]  freed_q;

  // frame queue memory
  logic [frsa_pkg::FENCE_W-1:0]  fence_mem [FRAME_SLOTS];
  logic [OFFSET_BITS-1:0]        tail_mem  [FRAME_SLOTS];
  logic [frsa_pkg::SIZE_W-1:0]   size_mem  [FRAME_SLOTS];
  logic [frsa_pkg::FENCE_W-1:0]  rd_fence_q;
  logic [OFFSET_BITS-1:0]        rd_tail_q;
  logic [frsa_pkg::SIZE_W-1:0]   rd_size_q;

  logic q_full;
  assign q_full = (cnt_q == FULL_CNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !q_full) begin
      fence_mem[wr_ptr_q] <= fence_q;
      tail_mem[wr_ptr_q]  <= tail_q;
      size_mem[wr_ptr_q]  <= frame_q;
    end
    rd_fence_q <= fence_mem[rd_ptr_q];
    rd_tail_q  <= tail_mem[rd_ptr_q];
    rd_size_q  <= size_mem[rd_ptr_q];
  end

  // allocate check, one compare set on widened operands
  logic [CW-1:0]               t_ext, h_ext, s_ext, b_ext, ts_sum;
  logic                        at_full, fits_end, fits_front, fits_gap, tail_ahead;
  logic [frsa_pkg::SIZE_W-1:0] skip;
  logic                        alloc_ok, wrap_hit;
  logic [frsa_pkg::SIZE_W-1:0] charge;
  logic [OFFSET_BITS-1:0]      new_tail;

  always_comb begin
    t_ext      = CW'(tail_q);
    h_ext      = CW'(head_q);
    s_ext      = CW'(size_q);
    b_ext      = CW'(buf_size_q);
    ts_sum     = t_ext + s_ext;
    at_full    = (used_q == buf_size_q);
    tail_ahead = (t_ext >= h_ext);
    fits_end   = (ts_sum <= b_ext);
    fits_front = (s_ext <= h_ext);
    fits_gap   = (ts_sum <= h_ext);
    skip       = (b_ext > t_ext) ? frsa_pkg::SIZE_W'(b_ext - t_ext) : '0;
    alloc_ok   = 1'b0;
    wrap_hit   = 1'b0;
    charge     = size_q;
    new_tail   = OFFSET_BITS'(ts_sum);
    if (!at_full) begin
      if (tail_ahead) begin
        if (fits_end) begin
          alloc_ok = 1'b1;
        end else if (fits_front) begin
          // wrap to offset zero, charge the skipped end to the frame
          alloc_ok = 1'b1;
          wrap_hit = 1'b1;
          charge   = sat_add32(skip, size_q);
          new_tail = OFFSET_BITS'(s_ext);
        end
      end else if (fits_gap) begin
        alloc_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      size_q  <= s_axis_tdata[frsa_pkg::SIZE_W-1:0];
      fence_q <= s_axis_tdata[frsa_pkg::IN_DATA_W-1:frsa_pkg::SIZE_W];
    end
    if (cmd_i.alloc_chk) begin
      alloc_ok_q <= alloc_ok;
      wrap_q     <= wrap_hit;
      charge_q   <= charge;
      new_tail_q <= new_tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      used_q     <= '0;
      frame_q    <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cnt_q      <= '0;
      res_stat_q <= frsa_pkg::STAT_OK;
      res_ofs_q  <= '0;
      freed_q    <= '0;
    end else begin
      if (cmd_i.capture) begin
        res_stat_q <= frsa_pkg::STAT_OK;
        res_ofs_q  <= '0;
        freed_q    <= '0;
      end
      if (cmd_i.alloc_apply) begin
        if (alloc_ok_q) begin
          tail_q    <= new_tail_q;
          used_q    <= sat_add32(used_q, charge_q);
          frame_q   <= sat_add32(frame_q, charge_q);
          // a wrapped grant starts at offset zero
          res_ofs_q <= wrap_q ? '0 : frsa_pkg::SIZE_W'(tail_q);
        end else begin
          res_stat_q <= frsa_pkg::STAT_NO_SPACE;
        end
      end
      if (cmd_i.finish) begin
        if (q_full) begin
          res_stat_q <= frsa_pkg::STAT_QUEUE_FULL;
        end else begin
          wr_ptr_q <= next_slot(wr_ptr_q);
          cnt_q    <= CNT_W'(cnt_q + 1'b1);
          frame_q  <= '0;
        end
      end
      if (cmd_i.rel_pop) begin
        used_q   <= (rd_size_q <= used_q) ? used_q - rd_size_q : '0;
        head_q   <= rd_tail_q;
        rd_ptr_q <= next_slot(rd_ptr_q);
        cnt_q    <= CNT_W'(cnt_q - 1'b1);
        if (freed_q != FREED_MAX) begin
          freed_q <= freed_q + 1'b1;
        end
      end
    end
  end

  // output register
  logic                                out_vld_q;
  logic [frsa_pkg::OUT_DATA_W-1:0]     out_data_q;
  logic [1:0]                          out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {4'b0, freed_q, used_q, res_ofs_q};
      out_user_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign stat_o.q_empty   = (cnt_q == '0);
  assign stat_o.front_hit = (rd_fence_q <= fence_q);
  assign stat_o.out_free  = !out_vld_q || m_axis_tready;

endmodule

[design/fenced_ring_suballocator_top.sv]
// Top level of the fenced ring suballocator: controller, datapath and ports.
//
// Usage: an item enters on the s_axis channel (tuser = operation, tdata =
// request_size, fence) and yields exactly one result on m_axis (tuser =
// status, tdata = offset, used_bytes, frames_freed). The buffer size is set
// through the APB port at byte address 0; the user must set it only while
// the block is idle, as the block itself does not enforce this. Items are
// handled one at a time by the controller. After acceptance, an allocate
// passes the check and apply states, a finish frame the finish state, and a
// release alternates a memory read state and a fence compare state for each
// popped frame until the queue runs empty or a frame with a later fence
// stops it; an unknown operation goes straight to the result state. The next
// item is accepted the cycle after its result is loaded into the output register.
// Reset clears head, tail, used and frame counters, empties the frame queue
// and sets the buffer size to 65536; queue entries are not cleared.
// When the receiver stalls, the result holds in the output register; the
// next item is still accepted and worked on, and waits for the register.
module fenced_ring_suballocator_top #(
  parameter int unsigned FRAME_SLOTS = frsa_pkg::FRAME_SLOTS_DEF,
  parameter int unsigned OFFSET_BITS = frsa_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [frsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // request_size[31:0], fence[95:32]
  input  logic [1:0]                      s_axis_tuser,   // operation[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [frsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // offset[31:0], used_bytes[63:32],
                                                          // frames_freed[67:64], zero[71:68]
  output logic [1:0]                      m_axis_tuser,   // status[1:0]
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frsa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [frsa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [frsa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  frsa_pkg::cmd_t  cmd;
  frsa_pkg::stat_t stat;

  assign pready = 1'b1;

  frsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  frsa_dp #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

[design/frsa_checker.sv]
// Port-level checker for the fenced ring suballocator, bound to the top level.
module frsa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [frsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            pready
);

  // a result other than ok carries no offset and frees no frame
  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != frsa_pkg::STAT_OK |->
      m_axis_tdata[31:0] == '0 && m_axis_tdata[67:64] == '0)
    else $error("failed item reports an offset or freed frames");

  // the result status is always one of the ok, no-space and queue-full codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == frsa_pkg::STAT_OK ||
      m_axis_tuser == frsa_pkg::STAT_NO_SPACE || m_axis_tuser == frsa_pkg::STAT_QUEUE_FULL)
    else $error("result status outside the defined codes");

  // an item is never taken in the cycle right after another one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted back to back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind fenced_ring_suballocator_top frsa_checker u_frsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
